// File: hw/rtl/rmc_pkg.sv
// Shared constants and types for the random maze carver.
// No dependencies; imported by the top level and the decoder.
`default_nettype none

package rmc_pkg;

   // Default largest cell-grid side.
   localparam int MAX_CELL_SIDE_DEF = 16;

   // Map side after reset.
   localparam logic [5:0] MAP_SIDE_RST = 6'd25;

   // Request kinds.
   localparam logic KIND_INIT  = 1'b0;
   localparam logic KIND_CARVE = 1'b1;

   // Carve directions.
   localparam logic [1:0] DIR_POS_X = 2'd0;
   localparam logic [1:0] DIR_NEG_X = 2'd1;
   localparam logic [1:0] DIR_POS_Y = 2'd2;
   localparam logic [1:0] DIR_NEG_Y = 2'd3;

   // Status of a decoded request, passed from the decoder to the sequencer.
   typedef struct packed {
      logic       done;
      logic       legal;
      logic [5:0] wall_col;
      logic [5:0] wall_row;
   } carve_info_type;

endpackage

`default_nettype wire

// File: hw/rtl/random_maze_carver.sv
// Randomized Kruskal maze carver, top level with the control sequencer.
// Depends on rmc_pkg, rmc_decode and rmc_label_ram.
//
// A request is taken when start is high and busy is low, and each request
// returns exactly one result, shown for one cycle with rsp_strobe; the
// receiver cannot stall it. After reset the block sweeps the label store,
// writing all MAX_CELL_SIDE*MAX_CELL_SIDE entries (256 by default), with
// busy high. An init request repeats that sweep and replies after it ends.
// A carve refused on the decoded fields goes straight to the reply state,
// one refused because both cells already share a region replies once both
// labels are read, and one that opens a wall replies after the relabelling
// pass, which reads every label once through the store's single read port.
`default_nettype none

module random_maze_carver import rmc_pkg::*; #(
   parameter int MAX_CELL_SIDE = MAX_CELL_SIDE_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   // Request channel.
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_kind,
   input  wire logic [3:0] req_cell_x,
   input  wire logic [3:0] req_cell_y,
   input  wire logic [1:0] req_direction,
   // Result channel.
   output logic            rsp_strobe,
   output logic            rsp_opened,
   output logic      [5:0] rsp_wall_col,
   output logic      [5:0] rsp_wall_row,
   output logic            rsp_done_res,
   output logic      [7:0] rsp_joins_made,
   // Configuration register.
   input  wire logic       csr_wr_en,
   input  wire logic [5:0] csr_wr_data
);

   localparam int NW          = $clog2(MAX_CELL_SIDE + 1);
   localparam int IDX_W       = $clog2(MAX_CELL_SIDE * MAX_CELL_SIDE);
   localparam int NSQ_W       = 2 * NW;
   localparam int LABEL_DEPTH = MAX_CELL_SIDE * MAX_CELL_SIDE;
   localparam int SW          = IDX_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WIPE,
      ST_READ_THERE,
      ST_LOOK,
      ST_SCAN,
      ST_REPLY
   } state_type;

   state_type         state_ff;
   logic [5:0]        map_side_ff;
   logic [IDX_W-1:0]  count_ff;
   logic [IDX_W-1:0]  wipe_cnt_ff;
   logic              reply_pend_ff;
   logic [IDX_W-1:0]  there_ff;
   logic [IDX_W-1:0]  keep_ff;
   logic [IDX_W-1:0]  gone_ff;
   logic [SW-1:0]     scan_cnt_ff;
   logic              hit_vld_ff;
   logic [IDX_W-1:0]  hit_addr_ff;
   logic              opened_ff;
   logic [5:0]        col_ff;
   logic [5:0]        row_ff;
   logic              rsp_strobe_ff;
   logic              rsp_opened_ff;
   logic [5:0]        rsp_wall_col_ff;
   logic [5:0]        rsp_wall_row_ff;
   logic              rsp_done_ff;
   logic [7:0]        rsp_joins_ff;

   logic [IDX_W-1:0]  here_idx;
   logic [IDX_W-1:0]  there_idx;
   logic [NSQ_W-1:0]  cell_count;
   carve_info_type    info;
   logic              take;
   logic              scan_end;
   logic              wr_en_in;
   logic [IDX_W-1:0]  wr_addr_in;
   logic [IDX_W-1:0]  wr_data_in;
   logic [IDX_W-1:0]  rd_addr_in;
   logic [IDX_W-1:0]  rd_data;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_side_ff <= MAP_SIDE_RST;
      end else if (csr_wr_en) begin
         map_side_ff <= csr_wr_data;
      end
   end

   rmc_decode #(
      .MAX_CELL_SIDE (MAX_CELL_SIDE)
   ) u_decode (
      .map_side   (map_side_ff),
      .cell_x     (req_cell_x),
      .cell_y     (req_cell_y),
      .direction  (req_direction),
      .join_count (count_ff),
      .here_idx   (here_idx),
      .there_idx  (there_idx),
      .cell_count (cell_count),
      .info       (info)
   );

   rmc_label_ram #(
      .ADDR_W (IDX_W),
      .DATA_W (IDX_W),
      .DEPTH  (LABEL_DEPTH)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (wr_en_in),
      .wr_addr (wr_addr_in),
      .wr_data (wr_data_in),
      .rd_addr (rd_addr_in),
      .rd_data (rd_data)
   );

   assign busy     = (state_ff != ST_IDLE);
   assign take     = start && !busy;
   assign scan_end = (NSQ_W'(scan_cnt_ff) >= cell_count);

   // Store access: the sweep writes each index, the scan relabels hits in the
   // cycle after their read. Reads follow the sequencer.
   always_comb begin
      wr_en_in   = 1'b0;
      wr_addr_in = hit_addr_ff;
      wr_data_in = keep_ff;
      case (state_ff)
         ST_WIPE: begin
            wr_en_in   = 1'b1;
            wr_addr_in = wipe_cnt_ff;
            wr_data_in = wipe_cnt_ff;
         end
         ST_SCAN: begin
            wr_en_in = hit_vld_ff && (rd_data == gone_ff);
         end
         default: begin
            wr_en_in = 1'b0;
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         ST_READ_THERE: rd_addr_in = there_ff;
         ST_SCAN:       rd_addr_in = scan_cnt_ff[IDX_W-1:0];
         default:       rd_addr_in = here_idx;
      endcase
   end

   // Sequencer with its registered results.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_WIPE;
         count_ff      <= '0;
         wipe_cnt_ff   <= '0;
         reply_pend_ff <= 1'b0;
         hit_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         hit_vld_ff    <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  opened_ff <= 1'b0;
                  col_ff    <= info.wall_col;
                  row_ff    <= info.wall_row;
                  there_ff  <= there_idx;
                  if (req_kind == KIND_INIT) begin
                     count_ff      <= '0;
                     wipe_cnt_ff   <= '0;
                     reply_pend_ff <= 1'b1;
                     state_ff      <= ST_WIPE;
                  end else if (info.legal) begin
                     state_ff <= ST_READ_THERE;
                  end else begin
                     state_ff <= ST_REPLY;
                  end
               end
            end
            ST_WIPE: begin
               wipe_cnt_ff <= wipe_cnt_ff + IDX_W'(1);
               if (wipe_cnt_ff == IDX_W'(LABEL_DEPTH - 1)) begin
                  state_ff <= reply_pend_ff ? ST_REPLY : ST_IDLE;
               end
            end
            ST_READ_THERE: begin
               // Label of the chosen cell arrives now.
               keep_ff  <= rd_data;
               state_ff <= ST_LOOK;
            end
            ST_LOOK: begin
               // Label of the neighbour arrives now.
               gone_ff     <= rd_data;
               scan_cnt_ff <= '0;
               state_ff    <= (rd_data == keep_ff) ? ST_REPLY : ST_SCAN;
            end
            ST_SCAN: begin
               if (scan_end) begin
                  opened_ff <= 1'b1;
                  count_ff  <= count_ff + IDX_W'(1);
                  state_ff  <= ST_REPLY;
               end else begin
                  hit_vld_ff  <= 1'b1;
                  hit_addr_ff <= scan_cnt_ff[IDX_W-1:0];
                  scan_cnt_ff <= scan_cnt_ff + SW'(1);
               end
            end
            ST_REPLY: begin
               rsp_strobe_ff   <= 1'b1;
               rsp_opened_ff   <= opened_ff;
               rsp_wall_col_ff <= opened_ff ? col_ff : 6'd0;
               rsp_wall_row_ff <= opened_ff ? row_ff : 6'd0;
               rsp_done_ff     <= info.done;
               rsp_joins_ff    <= 8'(count_ff);
               reply_pend_ff   <= 1'b0;
               state_ff        <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_opened     = rsp_opened_ff;
   assign rsp_wall_col   = rsp_wall_col_ff;
   assign rsp_wall_row   = rsp_wall_row_ff;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_joins_made = rsp_joins_ff;

   // A result is only ever shown straight after the reply state.
   a_strobe_after_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_REPLY))
      else $error("result strobe without reply state");

   // The store is written only by the sweep or the relabelling pass.
   a_write_owner: assert property (@(posedge clock) disable iff (reset)
      wr_en_in |-> (state_ff == ST_WIPE || state_ff == ST_SCAN))
      else $error("label store written outside sweep or scan");

   // An accepted request always makes the block busy next cycle.
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      take |=> busy)
      else $error("request accepted but block not busy");

   // The scan never runs past the current number of cells.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (NSQ_W'(scan_cnt_ff) <= cell_count))
      else $error("scan ran past the cell count");

   // An opened wall always advances the join count.
   a_open_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && scan_end) |=> (count_ff == $past(count_ff) + IDX_W'(1)))
      else $error("join not counted");

endmodule

`default_nettype wire

// File: hw/rtl/rmc_label_ram.sv
// Region label store: one write port and one registered read port.
// Uses no package items.
`default_nettype none

module rmc_label_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rmc_decode.sv
// Request decoder: grid side, completion test, neighbour check, label
// addresses and wall position. Depends on rmc_pkg.
`default_nettype none

module rmc_decode import rmc_pkg::*; #(
   parameter int MAX_CELL_SIDE = MAX_CELL_SIDE_DEF,
   localparam int NW     = $clog2(MAX_CELL_SIDE + 1),
   localparam int IDX_W  = $clog2(MAX_CELL_SIDE * MAX_CELL_SIDE),
   localparam int NSQ_W  = 2 * NW
) (
   input  wire logic [5:0]       map_side,
   input  wire logic [3:0]       cell_x,
   input  wire logic [3:0]       cell_y,
   input  wire logic [1:0]       direction,
   input  wire logic [IDX_W-1:0] join_count,
   output logic      [IDX_W-1:0] here_idx,
   output logic      [IDX_W-1:0] there_idx,
   output logic      [NSQ_W-1:0] cell_count,
   output carve_info_type        info
);

   localparam int PW = NW + 6;
   localparam int CW = NSQ_W + 1;

   logic [4:0]    half;
   logic [NW-1:0] n_val;
   logic [4:0]    nx;
   logic [4:0]    ny;
   logic          nb_ok;
   logic          on_grid;
   logic          done_flag;
   logic          legal_flag;
   logic [5:0]    wall_col;
   logic [5:0]    wall_row;
   logic [PW-1:0] here_sum;
   logic [PW-1:0] there_sum;

   // Grid side is half the map side less one, limited to the largest grid.
   always_comb begin
      half  = (map_side == 6'd0) ? 5'd0 : 5'((map_side - 6'd1) >> 1);
      n_val = (int'(half) > MAX_CELL_SIDE) ? NW'(MAX_CELL_SIDE) : NW'(half);
   end

   // Cell count and completion: done once joins reach cells less one.
   assign cell_count = NSQ_W'(n_val) * NSQ_W'(n_val);
   assign done_flag  = (CW'(join_count) + CW'(1)) >= CW'(cell_count);

   // Neighbour position and wall location for each direction.
   always_comb begin
      nx       = {1'b0, cell_x};
      ny       = {1'b0, cell_y};
      nb_ok    = 1'b0;
      wall_col = {1'b0, cell_x, 1'b1};
      wall_row = {1'b0, cell_y, 1'b1};
      case (direction)
         DIR_POS_X: begin
            nb_ok    = (int'(cell_x) + 1) < int'(n_val);
            nx       = {1'b0, cell_x} + 5'd1;
            wall_col = {1'b0, cell_x, 1'b0} + 6'd2;
         end
         DIR_NEG_X: begin
            nb_ok    = (cell_x != 4'd0);
            nx       = {1'b0, cell_x} - 5'd1;
            wall_col = {1'b0, cell_x, 1'b0};
         end
         DIR_POS_Y: begin
            nb_ok    = (int'(cell_y) + 1) < int'(n_val);
            ny       = {1'b0, cell_y} + 5'd1;
            wall_row = {1'b0, cell_y, 1'b0} + 6'd2;
         end
         DIR_NEG_Y: begin
            nb_ok    = (cell_y != 4'd0);
            ny       = {1'b0, cell_y} - 5'd1;
            wall_row = {1'b0, cell_y, 1'b0};
         end
         default: begin
            nb_ok = 1'b0;
         end
      endcase
   end

   // A carve may go ahead only on the grid, with a neighbour, before done.
   assign on_grid    = (int'(cell_x) < int'(n_val)) && (int'(cell_y) < int'(n_val));
   assign legal_flag = !done_flag && on_grid && nb_ok;
   assign info       = {done_flag, legal_flag, wall_col, wall_row};

   // Label addresses, row major with the current grid side.
   assign here_sum  = PW'(cell_x) + PW'(cell_y) * PW'(n_val);
   assign there_sum = PW'(nx) + PW'(ny) * PW'(n_val);
   assign here_idx  = here_sum[IDX_W-1:0];
   assign there_idx = there_sum[IDX_W-1:0];

endmodule

`default_nettype wire

// File: verif/random_maze_carver_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for random_maze_carver: directed corner cases, then
// random maze-carving sessions, all checked against a region-label model.
// Depends on rmc_pkg and the random_maze_carver RTL only.

import rmc_pkg::*;

// One result beat as the block reports it.
typedef struct packed {
   logic       opened;
   logic [5:0] wall_col;
   logic [5:0] wall_row;
   logic       done_res;
   logic [7:0] joins_made;
} wall_report_type;

// One carve request: a cell and the direction of the wall to knock through.
typedef struct packed {
   logic [3:0] x;
   logic [3:0] y;
   logic [1:0] dir;
} carve_type;

// Cell-grid side for a given map side, clamped to the largest grid.
function automatic int grid_side_of(input logic [5:0] side);
   int n;
   n = (side >= 1) ? (int'(side) - 1) / 2 : 0;
   if (n > MAX_CELL_SIDE_DEF) n = MAX_CELL_SIDE_DEF;
   return n;
endfunction

// Tracks the region labels and join count, works out the report owed for
// every accepted request beat and checks the result beats against them.
class region_scoreboard;
   logic [5:0]      map_side;
   logic [7:0]      labels [0:255];
   int              joins;
   wall_report_type owed_reports [$];
   int              wrong_count;

   function new();
      map_side = MAP_SIDE_RST;
      wrong_count = 0;
      clear_regions();
   endfunction

   // Every cell becomes a region of its own and the join count restarts.
   function void clear_regions();
      int i;
      for (i = 0; i < 256; i++) labels[i] = 8'(i);
      joins = 0;
   endfunction

   function bit maze_done();
      int n;
      n = grid_side_of(map_side);
      return (joins + 1) >= (n * n);
   endfunction

   // Apply one accepted request and queue the report it must produce.
   function void note_request(input logic kind, input carve_type c);
      wall_report_type rep;
      int n, cx, cy, nx, ny, i;
      logic [7:0] keep, gone;
      bit ok;
      rep = '0;
      n = grid_side_of(map_side);
      cx = c.x;
      cy = c.y;
      if (kind == KIND_INIT) begin
         clear_regions();
      end else if (!maze_done() && cx < n && cy < n) begin
         nx = cx;
         ny = cy;
         ok = 1'b1;
         case (c.dir)
            DIR_POS_X: if (cx + 1 < n) nx = cx + 1; else ok = 1'b0;
            DIR_NEG_X: if (cx > 0) nx = cx - 1; else ok = 1'b0;
            DIR_POS_Y: if (cy + 1 < n) ny = cy + 1; else ok = 1'b0;
            default:   if (cy > 0) ny = cy - 1; else ok = 1'b0;
         endcase
         if (ok) begin
            keep = labels[cx + cy * n];
            gone = labels[nx + ny * n];
            // Different regions: fold the neighbour's region into ours.
            if (keep != gone) begin
               for (i = 0; i < n * n; i++)
                  if (labels[i] == gone) labels[i] = keep;
               case (c.dir)
                  DIR_POS_X: begin
                     rep.wall_col = 6'(2 * cx + 2);
                     rep.wall_row = 6'(2 * cy + 1);
                  end
                  DIR_NEG_X: begin
                     rep.wall_col = 6'(2 * cx);
                     rep.wall_row = 6'(2 * cy + 1);
                  end
                  DIR_POS_Y: begin
                     rep.wall_col = 6'(2 * cx + 1);
                     rep.wall_row = 6'(2 * cy + 2);
                  end
                  default: begin
                     rep.wall_col = 6'(2 * cx + 1);
                     rep.wall_row = 6'(2 * cy);
                  end
               endcase
               rep.opened = 1'b1;
               joins++;
            end
         end
      end
      rep.done_res = maze_done();
      rep.joins_made = 8'(joins);
      owed_reports.push_back(rep);
   endfunction

   // Compare one result beat with the oldest owed report.
   function void check_result(input wall_report_type got);
      wall_report_type want;
      if (owed_reports.size() == 0) begin
         wrong_count++;
         if (wrong_count <= 10)
            $display("unexpected result beat: opened %0d col %0d row %0d %s %0d %s %0d",
                     got.opened, got.wall_col, got.wall_row, "done",
                     got.done_res, "joins", got.joins_made);
         return;
      end
      want = owed_reports.pop_front();
      if (got.opened !== want.opened || got.wall_col !== want.wall_col ||
          got.wall_row !== want.wall_row || got.done_res !== want.done_res ||
          got.joins_made !== want.joins_made) begin
         wrong_count++;
         if (wrong_count <= 10) begin
            $display("result mismatch at %0t:", $realtime);
            $display("  expected opened %0d col %0d row %0d done %0d joins %0d",
                     want.opened, want.wall_col, want.wall_row,
                     want.done_res, want.joins_made);
            $display("  got      opened %0d col %0d row %0d done %0d joins %0d",
                     got.opened, got.wall_col, got.wall_row,
                     got.done_res, got.joins_made);
         end
      end
   endfunction
endclass

module random_maze_carver_test;

   localparam int unsigned CYCLE_LIMIT = 2_500_000;
   // Longest reply: a full relabelling pass over a 16-by-16 grid.
   localparam int DRAIN_CYCLES = 300;

   logic       clock;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_kind = KIND_INIT;
   logic [3:0] req_cell_x = 4'd0;
   logic [3:0] req_cell_y = 4'd0;
   logic [1:0] req_direction = DIR_POS_X;
   logic       rsp_strobe;
   logic       rsp_opened;
   logic [5:0] rsp_wall_col;
   logic [5:0] rsp_wall_row;
   logic       rsp_done_res;
   logic [7:0] rsp_joins_made;
   logic       csr_wr_en = 1'b0;
   logic [5:0] csr_wr_data = MAP_SIDE_RST;

   region_scoreboard tracker;
   int unsigned      cycle_count = 0;
   int unsigned      sent = 0;
   int               gap_pct = 0;

   random_maze_carver u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_direction  (req_direction),
      .rsp_strobe     (rsp_strobe),
      .rsp_opened     (rsp_opened),
      .rsp_wall_col   (rsp_wall_col),
      .rsp_wall_row   (rsp_wall_row),
      .rsp_done_res   (rsp_done_res),
      .rsp_joins_made (rsp_joins_made),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // 12 ns clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** random_maze_carver: FAILED **");
         $finish;
      end
   end

   // Every strobed result beat goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1)
         tracker.check_result({rsp_opened, rsp_wall_col, rsp_wall_row,
                               rsp_done_res, rsp_joins_made});
   end

   function automatic carve_type make_carve(input int x, input int y,
                                            input logic [1:0] dir);
      carve_type c;
      c.x = 4'(x);
      c.y = 4'(y);
      c.dir = dir;
      return c;
   endfunction

   // Mostly small grids, now and then a large one or an out-of-range side.
   function automatic logic [5:0] pick_side();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 6'($urandom_range(3, 13));
      else if (r < 85) return 6'($urandom_range(14, 25));
      else if (r < 95) return 6'($urandom_range(26, 33));
      return 6'($urandom_range(63));
   endfunction

   // Present one request beat and hold it until the block takes it. In each
   // cycle the sender idles with start low at the current idle rate.
   task automatic send_request(input logic kind, input carve_type c);
      bit taken;
      taken = 1'b0;
      req_kind <= kind;
      req_cell_x <= c.x;
      req_cell_y <= c.y;
      req_direction <= c.dir;
      while (!taken) begin
         start <= ($urandom_range(99) >= gap_pct);
         @(posedge clock);
         taken = (start === 1'b1) && (busy === 1'b0);
      end
      tracker.note_request(kind, c);
      sent++;
   endtask

   // A carve with every field random, or kept on the current grid.
   task automatic random_carve(input bit on_grid);
      int n;
      carve_type c;
      n = grid_side_of(tracker.map_side);
      c = make_carve($urandom_range(15), $urandom_range(15), 2'($urandom_range(3)));
      if (on_grid && n > 0) begin
         c.x = 4'($urandom_range(n - 1));
         c.y = 4'($urandom_range(n - 1));
      end
      send_request(KIND_CARVE, c);
   endtask

   // Stop offering beats and wait until every owed report is in.
   task automatic finish_outstanding();
      start <= 1'b0;
      do @(posedge clock);
      while (tracker.owed_reports.size() != 0 || busy !== 1'b0);
   endtask

   task automatic write_side(input logic [5:0] side);
      csr_wr_en <= 1'b1;
      csr_wr_data <= side;
      @(posedge clock);
      tracker.map_side = side;
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_directed();
      // Wait out the label sweep after reset.
      finish_outstanding();
      // Reset map side: a 12-by-12 grid.
      send_request(KIND_INIT, make_carve(0, 0, DIR_POS_X));
      send_request(KIND_CARVE, make_carve(11, 11, DIR_POS_X));   // neighbour off the grid
      send_request(KIND_CARVE, make_carve(11, 11, DIR_NEG_X));
      send_request(KIND_CARVE, make_carve(15, 15, DIR_NEG_Y));   // cell off the grid

      // A 2-by-2 grid carved to completion, with refusals along the way.
      finish_outstanding();
      write_side(6'd5);
      send_request(KIND_INIT, make_carve(15, 15, DIR_NEG_Y));
      send_request(KIND_CARVE, make_carve(0, 0, DIR_POS_X));
      send_request(KIND_CARVE, make_carve(1, 0, DIR_NEG_X));     // same region
      send_request(KIND_CARVE, make_carve(0, 0, DIR_NEG_X));
      send_request(KIND_CARVE, make_carve(0, 0, DIR_NEG_Y));
      send_request(KIND_CARVE, make_carve(0, 1, DIR_POS_Y));
      send_request(KIND_CARVE, make_carve(0, 0, DIR_POS_Y));
      send_request(KIND_CARVE, make_carve(1, 1, DIR_NEG_Y));     // last join
      send_request(KIND_CARVE, make_carve(1, 1, DIR_NEG_X));     // carve after done

      // Map side beyond the largest grid: the grid side is clamped.
      finish_outstanding();
      write_side(6'd63);
      send_request(KIND_INIT, make_carve(0, 0, DIR_POS_X));
      send_request(KIND_CARVE, make_carve(15, 15, DIR_NEG_Y));
      send_request(KIND_CARVE, make_carve(15, 15, DIR_POS_Y));

      // Largest legal side, keeping the old labels.
      finish_outstanding();
      write_side(6'd33);
      send_request(KIND_CARVE, make_carve(0, 0, DIR_POS_X));
      send_request(KIND_CARVE, make_carve(15, 14, DIR_POS_Y));

      // Tiny sides leave no grid at all, so the maze counts as done.
      finish_outstanding();
      write_side(6'd1);
      send_request(KIND_CARVE, make_carve(0, 0, DIR_POS_X));
      send_request(KIND_INIT, make_carve(0, 0, DIR_POS_X));
      finish_outstanding();
      write_side(6'd0);
      send_request(KIND_CARVE, make_carve(0, 0, DIR_POS_Y));

      // Smallest legal side: a single cell, done from the start.
      finish_outstanding();
      write_side(6'd3);
      send_request(KIND_INIT, make_carve(0, 0, DIR_POS_X));
      send_request(KIND_CARVE, make_carve(0, 0, DIR_POS_X));
   endtask

   // One maze: optionally a new side, usually an init, then the grid's walls
   // in shuffled order with some noise mixed in, sometimes cut short.
   task automatic run_episode(input int unsigned stop_at);
      carve_type walls [$];
      carve_type w;
      int n, i, j, keep_len, extra;
      finish_outstanding();
      if ($urandom_range(5) != 0) write_side(pick_side());
      n = grid_side_of(tracker.map_side);
      if ($urandom_range(7) != 0)
         send_request(KIND_INIT, make_carve($urandom_range(15), $urandom_range(15),
                                            2'($urandom_range(3))));

      // Every inner wall once, named from either of its two cells.
      for (j = 0; j < n; j++) begin
         for (i = 0; i < n; i++) begin
            if (i + 1 < n) begin
               w = $urandom_range(1) ? make_carve(i, j, DIR_POS_X)
                                     : make_carve(i + 1, j, DIR_NEG_X);
               walls.push_back(w);
            end
            if (j + 1 < n) begin
               w = $urandom_range(1) ? make_carve(i, j, DIR_POS_Y)
                                     : make_carve(i, j + 1, DIR_NEG_Y);
               walls.push_back(w);
            end
         end
      end
      for (i = walls.size() - 1; i > 0; i--) begin
         j = $urandom_range(i);
         w = walls[i];
         walls[i] = walls[j];
         walls[j] = w;
      end

      keep_len = walls.size();
      if ($urandom_range(4) == 0) keep_len = $urandom_range(walls.size());
      for (i = 0; i < keep_len && sent < stop_at; i++) begin
         if ($urandom_range(99) < 12) begin
            if ($urandom_range(9) == 0)
               send_request(KIND_INIT, make_carve($urandom_range(15), $urandom_range(15),
                                                  2'($urandom_range(3))));
            else
               random_carve(1'b0);
         end
         if (sent < stop_at) send_request(KIND_CARVE, walls[i]);
      end

      // A few carves once the maze should be complete.
      extra = $urandom_range(1, 3);
      for (i = 0; i < extra && sent < stop_at; i++) random_carve(1'b1);
   endtask

   task automatic run_phase(input int pct, input int unsigned count);
      int unsigned target;
      gap_pct = pct;
      target = sent + count;
      while (sent < target) run_episode(target);
   endtask

   initial begin
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      gap_pct = 33;
      run_directed();
      run_phase(33, 360);
      run_phase(75, 360);
      run_phase(0, 360);

      // Let any stray beat show itself before the verdict.
      finish_outstanding();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.wrong_count == 0 && tracker.owed_reports.size() == 0) begin
         $display("** random_maze_carver: PASSED **");
      end else begin
         $display("** random_maze_carver: FAILED **");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/rmc_pkg.sv
hw/rtl/rmc_label_ram.sv
hw/rtl/rmc_decode.sv
hw/rtl/random_maze_carver.sv
verif/random_maze_carver_test.sv
